>>> rtl/lzbd_pkg.sv
// Shared types and constants of the back-reference stream decompressor.
`default_nettype none
package lzbd_pkg;

  // Decoder position within the compressed stream.
  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_ITEM = 2'd1,
    PH_REF2 = 2'd2,
    PH_REF3 = 2'd3
  } phase_t;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_LIT  = 2'd1,
    S_RD   = 2'd2,
    S_WR   = 2'd3
  } state_t;

  localparam logic [7:0] FLAG_MSB    = 8'h80;
  localparam logic [7:0] NIBBLE_MASK = 8'h0F;
  localparam logic [8:0] LONG_BIAS   = 9'h012;
  localparam logic [8:0] SHORT_BIAS  = 9'd2;
  localparam int         DIST_W      = 13;
  localparam int         LEN_W       = 9;
  localparam logic [0:0] REG_OUTPUT_SIZE = 1'b0;

endpackage
`default_nettype wire

>>> rtl/lzbd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> rtl/lz_backref_stream_decompressor.sv
// Top level of the back-reference stream decompressor.
// A literal is taken in S_IDLE and emitted from S_LIT into its group, which then closes
// into the output register; after the final reference byte of a copy, each produced byte is
// read from history in S_RD and written back in S_WR. Code bytes and leading reference bytes
// are taken in S_IDLE alone. A full output register that is not taken holds an emit that
// closes a group, and with it the input, until it drains.
// Reset (rst_n low, synchronous) clears the decoder state, byte count and size;
// the history memory is not cleared.
`default_nettype none
module lz_backref_stream_decompressor
  import lzbd_pkg::*;
#(
  parameter int WINDOW_DEPTH = 4096,
  parameter int OUT_LANES    = 8
) (
  input  wire logic clk,
  input  wire logic rst_n,
  // Input request channel.
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,  // [7:0] in_byte
  input  wire logic       in_tuser,  // [0] start_stream
  // Result channel.
  output logic            out_tvalid,
  input  wire logic       out_tready,
  // lane0 at [7:0] upward, then byte_count, zero padded to whole bytes.
  output logic [((OUT_LANES*8+$clog2(OUT_LANES+1)+7)/8)*8-1:0] out_tdata,
  output logic            out_tlast,  // last_of_run
  output logic [1:0]      out_tuser,  // [0] stream_done, [1] bad_reference
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int AW     = $clog2(WINDOW_DEPTH);
  localparam int FW     = $clog2(OUT_LANES);
  localparam int CW     = $clog2(OUT_LANES+1);
  localparam int LANEW  = OUT_LANES*8;
  localparam int TDW    = ((LANEW+CW+7)/8)*8;

  // Configuration register.
  logic [31:0] size_r;
  logic        cfg_wr;
  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_OUTPUT_SIZE);
  assign cfg_prdata = (cfg_paddr[2] == REG_OUTPUT_SIZE) ? size_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 32'd0;
    end else if (cfg_wr) begin
      size_r <= cfg_pwdata;
    end
  end

  // Decoder state.
  state_t            state_r, state_nxt;
  phase_t            phase_r, phase_nxt;
  logic [7:0]        flag_r, flag_nxt;
  logic [3:0]        left_r, left_nxt;
  logic [7:0]        first_r, first_nxt;
  logic [7:0]        lit_r, lit_nxt;
  logic [31:0]       prod_r, prod_nxt;
  logic [AW-1:0]     src_r, src_nxt;
  logic [LEN_W-1:0]  rem_r, rem_nxt;
  logic [DIST_W-1:0] zero_r, zero_nxt;
  logic              bad_r, bad_nxt;

  // Group being assembled and the output register.
  logic [7:0]        grp_r [OUT_LANES];
  logic [7:0]        grp_nxt [OUT_LANES];
  logic [FW-1:0]     fill_r, fill_nxt;
  logic [LANEW-1:0]  olanes_r, olanes_nxt;
  logic [CW-1:0]     ocnt_r, ocnt_nxt;
  logic              olast_r, olast_nxt;
  logic              odone_r, odone_nxt;
  logic              obad_r, obad_nxt;
  logic              ovalid_r, ovalid_nxt;

  // History memory.
  logic          ram_we, ram_re;
  logic [7:0]    ram_q, ram_wdata;
  logic [AW-1:0] ram_raddr;

  lzbd_ram #(.WIDTH(8), .DEPTH(WINDOW_DEPTH)) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (prod_r[AW-1:0]),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_q)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {{(TDW-LANEW-CW){1'b0}}, ocnt_r, olanes_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = {obad_r, odone_r};

  logic              accept;
  logic              start;
  phase_t            eff_phase;
  logic [31:0]       eff_prod;
  logic [7:0]        sec;
  logic [DIST_W-1:0] ref_dist;
  logic [32:0]       nprod;
  logic              reach;
  logic              emit_req, emit_lit, last_byte, close, room, emit;
  logic [7:0]        emit_val;
  logic [3:0]        left_dec;

  always_comb begin
    accept    = in_tvalid && in_tready;
    start     = in_tuser;
    eff_phase = start ? PH_CODE : phase_r;
    eff_prod  = start ? 32'd0 : prod_r;
    sec       = (eff_phase == PH_REF2) ? in_tdata : lit_r;
    ref_dist  = DIST_W'({(first_r & NIBBLE_MASK), sec}) + DIST_W'(1);
    nprod     = {1'b0, prod_r} + 33'd1;
    reach     = nprod >= {1'b0, size_r};

    state_nxt = state_r;
    phase_nxt = phase_r;
    flag_nxt  = flag_r;
    left_nxt  = left_r;
    first_nxt = first_r;
    lit_nxt   = lit_r;
    prod_nxt  = prod_r;
    src_nxt   = src_r;
    rem_nxt   = rem_r;
    zero_nxt  = zero_r;
    bad_nxt   = bad_r;
    grp_nxt   = grp_r;
    fill_nxt  = fill_r;
    olanes_nxt = olanes_r;
    ocnt_nxt  = ocnt_r;
    olast_nxt = olast_r;
    odone_nxt = odone_r;
    obad_nxt  = obad_r;
    ovalid_nxt = ovalid_r && !out_tready;
    ram_re    = 1'b0;
    ram_raddr = src_r;

    // Shared emit path: one byte into the group, the group out when it closes.
    emit_lit  = (state_r == S_LIT);
    emit_req  = emit_lit || (state_r == S_WR);
    emit_val  = emit_lit ? lit_r : ((zero_r != '0) ? 8'd0 : ram_q);
    last_byte = emit_lit || (rem_r == LEN_W'(1)) || reach;
    close     = (fill_r == FW'(OUT_LANES-1)) || last_byte;
    room      = !(close && ovalid_r && !out_tready);
    emit      = emit_req && room;
    ram_we    = emit;
    ram_wdata = emit_val;
    left_dec  = (left_r != 4'd0) ? left_r - 4'd1 : 4'd0;

    if (emit) begin
      prod_nxt = nprod[31:0];
      grp_nxt[fill_r] = emit_val;
      if (close) begin
        for (int i = 0; i < OUT_LANES; i++) begin
          olanes_nxt[i*8 +: 8] = grp_nxt[i];
          grp_nxt[i] = 8'd0;
        end
        ocnt_nxt   = CW'(fill_r) + CW'(1);
        olast_nxt  = last_byte;
        odone_nxt  = reach;
        obad_nxt   = emit_lit ? 1'b0 : bad_r;
        ovalid_nxt = 1'b1;
        fill_nxt   = '0;
      end else begin
        fill_nxt = fill_r + FW'(1);
      end
      if (last_byte) begin
        // Item finished: shift to the next flag.
        flag_nxt  = {flag_r[6:0], 1'b0};
        left_nxt  = left_dec;
        phase_nxt = (left_dec == 4'd0) ? PH_CODE : PH_ITEM;
        state_nxt = S_IDLE;
      end else begin
        src_nxt   = src_r + AW'(1);
        rem_nxt   = rem_r - LEN_W'(1);
        if (zero_r != '0) begin
          zero_nxt = zero_r - DIST_W'(1);
        end
        state_nxt = S_RD;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (start) begin
            flag_nxt  = 8'd0;
            left_nxt  = 4'd0;
            phase_nxt = PH_CODE;
            first_nxt = 8'd0;
            prod_nxt  = 32'd0;
          end
          lit_nxt = in_tdata;
          if (eff_prod < size_r) begin
            // The short form takes its length from the first reference byte.
            rem_nxt = (eff_phase == PH_REF2)
                    ? LEN_W'(first_r[7:4]) + SHORT_BIAS
                    : LEN_W'(in_tdata) + LONG_BIAS;
            bad_nxt  = {19'd0, ref_dist} > eff_prod;
            zero_nxt = bad_nxt ? ref_dist - eff_prod[DIST_W-1:0] : '0;
            src_nxt  = eff_prod[AW-1:0] - AW'(ref_dist);
            case (eff_phase)
              PH_ITEM: begin
                if ((flag_r & FLAG_MSB) != 8'd0) begin
                  state_nxt = S_LIT;
                end else begin
                  first_nxt = in_tdata;
                  phase_nxt = PH_REF2;
                end
              end
              PH_REF2: begin
                if (first_r[7:4] != 4'd0) begin
                  state_nxt = S_RD;
                end else begin
                  lit_nxt   = in_tdata;
                  phase_nxt = PH_REF3;
                end
              end
              PH_REF3: begin
                state_nxt = S_RD;
              end
              default: begin
                flag_nxt  = in_tdata;
                left_nxt  = 4'd8;
                phase_nxt = PH_ITEM;
              end
            endcase
          end
        end
      end
      S_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_WR;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      phase_r  <= PH_CODE;
      flag_r   <= 8'd0;
      left_r   <= 4'd0;
      first_r  <= 8'd0;
      prod_r   <= 32'd0;
      fill_r   <= '0;
      ovalid_r <= 1'b0;
      for (int i = 0; i < OUT_LANES; i++) begin
        grp_r[i] <= 8'd0;
      end
    end else begin
      state_r  <= state_nxt;
      phase_r  <= phase_nxt;
      flag_r   <= flag_nxt;
      left_r   <= left_nxt;
      first_r  <= first_nxt;
      prod_r   <= prod_nxt;
      fill_r   <= fill_nxt;
      ovalid_r <= ovalid_nxt;
      grp_r    <= grp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lit_r    <= lit_nxt;
    src_r    <= src_nxt;
    rem_r    <= rem_nxt;
    zero_r   <= zero_nxt;
    bad_r    <= bad_nxt;
    olanes_r <= olanes_nxt;
    ocnt_r   <= ocnt_nxt;
    olast_r  <= olast_nxt;
    odone_r  <= odone_nxt;
    obad_r   <= obad_nxt;
  end

`ifndef ASSERT_OFF
  // Every item closes its last group, so no partial group waits between requests.
  a_empty_group: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> fill_r == '0) else $error("partial group left between items");

  // A delivered group carries between one and OUT_LANES bytes.
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (ocnt_r != '0) && (ocnt_r <= CW'(OUT_LANES)))
    else $error("group byte count out of range");

  // A copy byte is always preceded by its history read.
  a_read_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) && $past(state_r) != S_WR |-> $past(state_r) == S_RD)
    else $error("copy write without history read");
`endif

endmodule
`default_nettype wire
